### rtl/etuc_pkg.sv
// Package for the epoch to UTC calendar block: sequencer states, constants, calendar functions.
`default_nettype none

package etuc_pkg;

  localparam int DEFAULT_EPOCH_BITS = 36;
  localparam int MIN_SUB_BITS       = 18;
  localparam int SECS_PER_DAY       = 86400;
  localparam int SECS_PER_HOUR      = 3600;
  localparam int SECS_PER_MIN       = 60;
  localparam int DAYS_PER_400Y      = 146097;
  localparam int DAYS_PER_WEEK      = 7;
  localparam int YEARS_PER_CYCLE    = 400;
  localparam int YEAR_BASE          = 70;
  localparam int CYCLE_POS_START    = 370;
  localparam int HOUR_STEPS         = 5;
  localparam int MIN_STEPS          = 6;
  localparam int WDAY_STEPS         = 15;

  localparam logic [3:0] MONTH_JAN = 4'd0;
  localparam logic [3:0] MONTH_FEB = 4'd1;
  localparam logic [3:0] MONTH_APR = 4'd3;
  localparam logic [3:0] MONTH_JUN = 4'd5;
  localparam logic [3:0] MONTH_SEP = 4'd8;
  localparam logic [3:0] MONTH_NOV = 4'd10;
  localparam logic [3:0] MONTH_DEC = 4'd11;

  typedef enum logic [3:0] {
    S_IDLE,
    S_DAY,
    S_HOUR,
    S_MIN,
    S_CYC,
    S_WDAY,
    S_YEAR4,
    S_YEAR1,
    S_MONTH,
    S_WRITE
  } state_t;

  function automatic logic [8:0] cycle_add(input logic [8:0] pos, input logic [2:0] step);
    logic [9:0] sum;
    sum = {1'b0, pos} + {7'd0, step};
    if (sum >= 10'(YEARS_PER_CYCLE)) begin
      return 9'(sum - 10'(YEARS_PER_CYCLE));
    end
    return sum[8:0];
  endfunction

  function automatic logic is_leap(input logic [8:0] pos);
    return (pos[1:0] == 2'b00) && (pos != 9'd100) && (pos != 9'd200) && (pos != 9'd300);
  endfunction

  function automatic logic [10:0] len_4y(input logic [8:0] pos);
    logic leap4;
    leap4 = is_leap(pos) | is_leap(cycle_add(pos, 3'd1)) |
            is_leap(cycle_add(pos, 3'd2)) | is_leap(cycle_add(pos, 3'd3));
    return leap4 ? 11'd1461 : 11'd1460;
  endfunction

  function automatic logic [8:0] len_1y(input logic [8:0] pos);
    return is_leap(pos) ? 9'd366 : 9'd365;
  endfunction

  function automatic logic [4:0] month_days(input logic [3:0] mon, input logic leap);
    logic [4:0] len;
    case (mon) inside
      MONTH_FEB: len = leap ? 5'd29 : 5'd28;
      MONTH_APR, MONTH_JUN, MONTH_SEP, MONTH_NOV: len = 5'd30;
      default: len = 5'd31;
    endcase
    return len;
  endfunction

endpackage

`default_nettype wire

### rtl/etuc_sub.sv
// Shared subtract and compare unit for the calendar sequencer.
`default_nettype none

module etuc_sub #(
  parameter int WIDTH = etuc_pkg::MIN_SUB_BITS
) (
  input  wire logic [WIDTH-1:0] a,
  input  wire logic [WIDTH-1:0] b,
  output logic      [WIDTH-1:0] diff,
  output logic                  ge
);

  logic [WIDTH:0] full;

  assign full = {1'b0, a} - {1'b0, b};
  assign diff = full[WIDTH-1:0];
  assign ge   = ~full[WIDTH];

endmodule

`default_nettype wire

### rtl/epoch_to_utc_calendar.sv
// Top level: seconds since 1970 to broken-down Gregorian UTC date and time.
//
//  channel | signals                          | direction | content
//  --------+----------------------------------+-----------+-------------------------------
//  in      | in_valid, in_ready               | to block  | epoch_seconds
//  out     | out_valid, out_ready             | from block| second .. day_of_month
//
// One beat runs a restoring division by shift and subtract, then up to 99 four-year strides and
// up to 3 single years, each of these walks closed by one failing compare, then up to 11 months,
// closed by a failing compare or by reaching December, and one write step.
// Division and walk steps share one subtract and compare unit; reset clears the sequencer
// and the output valid. A finished result sits in the output register; the next beat is
// taken meanwhile, and a result that finishes before the register frees holds in its write step.
`default_nettype none

module epoch_to_utc_calendar #(
  parameter int EPOCH_BITS = etuc_pkg::DEFAULT_EPOCH_BITS
) (
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire logic                  in_valid,
  output logic                       in_ready,
  input  wire logic [EPOCH_BITS-1:0] epoch_seconds,
  output logic                       out_valid,
  input  wire logic                  out_ready,
  output logic      [5:0]            second,
  output logic      [5:0]            minute,
  output logic      [4:0]            hour,
  output logic      [2:0]            weekday,
  output logic      [11:0]           year_from_1900,
  output logic      [8:0]            day_of_year,
  output logic      [3:0]            month,
  output logic      [4:0]            day_of_month
);

  import etuc_pkg::*;

  localparam int DAY_BITS = EPOCH_BITS - 16;
  localparam int CYC_BITS = (DAY_BITS >= 18) ? DAY_BITS - 17 : 1;
  localparam int SUB_W    = (DAY_BITS > MIN_SUB_BITS) ? DAY_BITS : MIN_SUB_BITS;
  localparam int CNT_W    = $clog2(EPOCH_BITS);

  state_t state, state_next;

  logic [EPOCH_BITS-1:0] num_q, num_next, num_shift;
  logic [17:0]           aux_q, aux_next;
  logic [SUB_W-1:0]      dval_q, dval_next;
  logic [CNT_W-1:0]      cnt_q, cnt_next;
  logic [4:0]            hr_q, hr_next;
  logic [5:0]            mn_q, mn_next;
  logic [5:0]            sc_q, sc_next;
  logic [CYC_BITS-1:0]   cyc_q, cyc_next;
  logic [11:0]           year_q, year_next;
  logic [8:0]            pos_q, pos_next;
  logic [8:0]            doy_q, doy_next;
  logic [3:0]            mon_q, mon_next;
  logic                  out_valid_next;
  logic                  load_out;

  logic [SUB_W-1:0] a_op, b_op, diff, keep;
  logic             ge;
  logic [2:0]       wd_mod;
  logic [2:0]       wd_val;

  etuc_sub #(
    .WIDTH(SUB_W)
  ) u_sub (
    .a   (a_op),
    .b   (b_op),
    .diff(diff),
    .ge  (ge)
  );

  assign keep      = ge ? diff : a_op;
  assign num_shift = {num_q[EPOCH_BITS-2:0], ge};
  assign wd_mod    = aux_q[2:0];
  assign wd_val    = (wd_mod >= 3'd3) ? 3'(wd_mod - 3'd3) : 3'(wd_mod + 3'd4);
  assign in_ready  = (state == S_IDLE);

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      out_valid <= 1'b0;
    end else begin
      state     <= state_next;
      out_valid <= out_valid_next;
    end
  end

  always_ff @(posedge clk) begin
    num_q  <= num_next;
    aux_q  <= aux_next;
    dval_q <= dval_next;
    cnt_q  <= cnt_next;
    hr_q   <= hr_next;
    mn_q   <= mn_next;
    sc_q   <= sc_next;
    cyc_q  <= cyc_next;
    year_q <= year_next;
    pos_q  <= pos_next;
    doy_q  <= doy_next;
    mon_q  <= mon_next;
    if (load_out) begin
      second         <= sc_q;
      minute         <= mn_q;
      hour           <= hr_q;
      weekday        <= wd_val;
      year_from_1900 <= year_q;
      day_of_year    <= doy_q;
      month          <= mon_q;
      day_of_month   <= 5'(dval_q[4:0] + 5'd1);
    end
  end

  always_comb begin
    state_next     = state;
    num_next       = num_q;
    aux_next       = aux_q;
    dval_next      = dval_q;
    cnt_next       = cnt_q;
    hr_next        = hr_q;
    mn_next        = mn_q;
    sc_next        = sc_q;
    cyc_next       = cyc_q;
    year_next      = year_q;
    pos_next       = pos_q;
    doy_next       = doy_q;
    mon_next       = mon_q;
    out_valid_next = out_valid && !out_ready;
    load_out       = 1'b0;
    a_op           = '0;
    b_op           = '0;

    unique case (state)
      S_IDLE: begin
        if (in_valid) begin
          num_next   = epoch_seconds;
          aux_next   = '0;
          cnt_next   = CNT_W'(EPOCH_BITS - 1);
          state_next = S_DAY;
        end
      end
      S_DAY: begin
        a_op     = SUB_W'({aux_q[16:0], num_q[EPOCH_BITS-1]});
        b_op     = SUB_W'(SECS_PER_DAY);
        num_next = num_shift;
        aux_next = keep[17:0];
        cnt_next = cnt_q - 1'b1;
        if (cnt_q == '0) begin
          dval_next  = SUB_W'(num_shift[DAY_BITS-1:0]);
          cnt_next   = CNT_W'(HOUR_STEPS - 1);
          state_next = S_HOUR;
        end
      end
      S_HOUR: begin
        a_op     = SUB_W'(aux_q);
        b_op     = SUB_W'(SECS_PER_HOUR) << cnt_q;
        hr_next  = {hr_q[3:0], ge};
        aux_next = keep[17:0];
        cnt_next = cnt_q - 1'b1;
        if (cnt_q == '0) begin
          cnt_next   = CNT_W'(MIN_STEPS - 1);
          state_next = S_MIN;
        end
      end
      S_MIN: begin
        a_op     = SUB_W'(aux_q);
        b_op     = SUB_W'(SECS_PER_MIN) << cnt_q;
        mn_next  = {mn_q[4:0], ge};
        aux_next = keep[17:0];
        cnt_next = cnt_q - 1'b1;
        if (cnt_q == '0) begin
          sc_next    = keep[5:0];
          cnt_next   = CNT_W'(CYC_BITS - 1);
          state_next = S_CYC;
        end
      end
      S_CYC: begin
        a_op      = dval_q;
        b_op      = SUB_W'(DAYS_PER_400Y) << cnt_q;
        cyc_next  = CYC_BITS'({cyc_q, ge});
        dval_next = keep;
        cnt_next  = cnt_q - 1'b1;
        if (cnt_q == '0) begin
          aux_next   = keep[17:0];
          cnt_next   = CNT_W'(WDAY_STEPS - 1);
          state_next = S_WDAY;
        end
      end
      S_WDAY: begin
        a_op     = SUB_W'(aux_q);
        b_op     = SUB_W'(DAYS_PER_WEEK) << cnt_q;
        aux_next = keep[17:0];
        cnt_next = cnt_q - 1'b1;
        if (cnt_q == '0) begin
          year_next  = 12'(32'(YEAR_BASE) + 32'(cyc_q) * 32'(YEARS_PER_CYCLE));
          pos_next   = 9'(CYCLE_POS_START);
          state_next = S_YEAR4;
        end
      end
      S_YEAR4: begin
        a_op = dval_q;
        b_op = SUB_W'(len_4y(pos_q));
        if (ge) begin
          dval_next = diff;
          year_next = year_q + 12'd4;
          pos_next  = cycle_add(pos_q, 3'd4);
        end else begin
          state_next = S_YEAR1;
        end
      end
      S_YEAR1: begin
        a_op = dval_q;
        b_op = SUB_W'(len_1y(pos_q));
        if (ge) begin
          dval_next = diff;
          year_next = year_q + 12'd1;
          pos_next  = cycle_add(pos_q, 3'd1);
        end else begin
          doy_next   = dval_q[8:0];
          mon_next   = MONTH_JAN;
          state_next = S_MONTH;
        end
      end
      S_MONTH: begin
        a_op = dval_q;
        b_op = SUB_W'(month_days(mon_q, is_leap(pos_q)));
        if (ge && (mon_q != MONTH_DEC)) begin
          dval_next = diff;
          mon_next  = mon_q + 4'd1;
        end else begin
          state_next = S_WRITE;
        end
      end
      S_WRITE: begin
        if (!out_valid || out_ready) begin
          load_out       = 1'b1;
          out_valid_next = 1'b1;
          state_next     = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

`ifndef ASSERT_OFF
  assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(state) == S_WRITE)
    else $error("result raised without a write step");

  assert property (@(posedge clk) disable iff (rst)
    state == S_DAY |-> aux_q < 18'(SECS_PER_DAY))
    else $error("day remainder out of range");

  assert property (@(posedge clk) disable iff (rst)
    (state == S_YEAR1 || state == S_MONTH) |-> pos_q < 9'(YEARS_PER_CYCLE))
    else $error("cycle position out of range");

  assert property (@(posedge clk) disable iff (rst)
    state == S_MONTH |-> mon_q <= MONTH_DEC)
    else $error("month walk overran December");
`endif

endmodule

`default_nettype wire
